// ===== rtl/obb_pkg.sv =====
// Shared types, constants and small decode tables for the oriented-box collision core.
// Used by obb_ctrl, obb_mac and obb_separating_axis_collision_core; depends on nothing.
`default_nettype none

package obb_pkg;

    // Field and internal widths.
    localparam int QW    = 16;   // quaternion component, Q1.14
    localparam int PW    = 32;   // position, Q16.16
    localparam int HW    = 31;   // half extent, unsigned Q15.16
    localparam int AW    = 25;   // axis component (matrix entries and cross products), Q.14
    localparam int CW    = 40;   // corner coordinate, Q16.16
    localparam int TW    = 50;   // projected corner, Q16.16
    localparam int DW    = 51;   // interval difference
    localparam int ACCW  = 66;   // accumulator
    localparam int OPAW  = 32;   // multiplier operand A
    localparam int OPBW  = 40;   // multiplier operand B
    localparam int BLOW  = 20;   // low slice of operand B
    localparam int FRAC  = 14;   // rounding shift
    localparam int AMEM  = 45;   // axis store: 15 axes of 3 components
    localparam int CMEM  = 48;   // corner store: 2 boxes, 8 corners, 3 components
    localparam int ADRW  = 6;

    localparam logic [3:0] LAST_AXIS = 4'd14;

    localparam logic signed [ACCW-1:0] RND_HALF = ACCW'(1) <<< (FRAC - 1);
    localparam logic signed [ACCW-1:0] ONE_Q28  = ACCW'(1) <<< 28;

    // Quaternion component selects.
    localparam logic [1:0] Q_W = 2'd0;
    localparam logic [1:0] Q_X = 2'd1;
    localparam logic [1:0] Q_Y = 2'd2;
    localparam logic [1:0] Q_Z = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAT,
        S_CROSS,
        S_CORN,
        S_PROJ,
        S_EVAL1,
        S_EVAL2,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        P_ADDR,
        P_OPER,
        P_LO,
        P_HI,
        P_ACC,
        P_WR
    } step_t;

    // Sequencer position handed to the datapath.
    typedef struct packed {
        state_t     st;
        step_t      ph;
        logic [1:0] term;
        logic [3:0] hi;
        logic [1:0] lo;
        logic [3:0] axis;
    } seq_t;

    // Controls of the shared multiply-accumulate unit.
    typedef struct packed {
        logic load;
        logic oper;
        logic mul_lo;
        logic mul_hi;
        logic add;
    } mac_ctl_t;

    // One product term of a rotation matrix entry: (+/-2*q[sa]) * q[sb].
    typedef struct packed {
        logic [1:0] sa;
        logic [1:0] sb;
        logic       neg;
    } mterm_t;

    // Matrix entry e = column*3 + row, two terms each.
    function automatic mterm_t mat_term(input logic [3:0] e, input logic t);
        mterm_t m;
        m = '{sa: Q_W, sb: Q_W, neg: 1'b0};
        case (e)
            4'd0: m = t ? mterm_t'{Q_Z, Q_Z, 1'b1} : mterm_t'{Q_Y, Q_Y, 1'b1};
            4'd1: m = t ? mterm_t'{Q_W, Q_Z, 1'b0} : mterm_t'{Q_X, Q_Y, 1'b0};
            4'd2: m = t ? mterm_t'{Q_W, Q_Y, 1'b1} : mterm_t'{Q_X, Q_Z, 1'b0};
            4'd3: m = t ? mterm_t'{Q_W, Q_Z, 1'b1} : mterm_t'{Q_X, Q_Y, 1'b0};
            4'd4: m = t ? mterm_t'{Q_Z, Q_Z, 1'b1} : mterm_t'{Q_X, Q_X, 1'b1};
            4'd5: m = t ? mterm_t'{Q_W, Q_X, 1'b0} : mterm_t'{Q_Y, Q_Z, 1'b0};
            4'd6: m = t ? mterm_t'{Q_W, Q_Y, 1'b0} : mterm_t'{Q_X, Q_Z, 1'b0};
            4'd7: m = t ? mterm_t'{Q_W, Q_X, 1'b1} : mterm_t'{Q_Y, Q_Z, 1'b0};
            4'd8: m = t ? mterm_t'{Q_Y, Q_Y, 1'b1} : mterm_t'{Q_X, Q_X, 1'b1};
            default: m = '{sa: Q_W, sb: Q_W, neg: 1'b0};
        endcase
        return m;
    endfunction

    // Splits a pair index 3*i + j (below nine) into {i, j}.
    function automatic logic [3:0] split3(input logic [3:0] v);
        logic [3:0] r;
        r = 4'd0;
        case (v)
            4'd0: r = {2'd0, 2'd0};
            4'd1: r = {2'd0, 2'd1};
            4'd2: r = {2'd0, 2'd2};
            4'd3: r = {2'd1, 2'd0};
            4'd4: r = {2'd1, 2'd1};
            4'd5: r = {2'd1, 2'd2};
            4'd6: r = {2'd2, 2'd0};
            4'd7: r = {2'd2, 2'd1};
            4'd8: r = {2'd2, 2'd2};
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // Component index plus one, modulo three.
    function automatic logic [1:0] next3(input logic [1:0] v);
        logic [1:0] r;
        r = 2'd0;
        case (v)
            2'd0: r = 2'd1;
            2'd1: r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [QW-1:0] pick4(input logic [1:0] s,
                                                   input logic signed [QW-1:0] w,
                                                   input logic signed [QW-1:0] x,
                                                   input logic signed [QW-1:0] y,
                                                   input logic signed [QW-1:0] z);
        logic signed [QW-1:0] r;
        r = w;
        case (s)
            Q_X: r = x;
            Q_Y: r = y;
            Q_Z: r = z;
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/obb_mac.sv =====
// Shared multiply-accumulate unit: a 32-bit by 40-bit product taken in two halves.
// Depends on obb_pkg for widths and the control struct.
`default_nettype none

module obb_mac (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire obb_pkg::mac_ctl_t                     ctl,
    input  wire logic signed [obb_pkg::OPAW-1:0]       op_a,
    input  wire logic signed [obb_pkg::OPBW-1:0]       op_b,
    input  wire logic signed [obb_pkg::ACCW-1:0]       bias,
    output logic signed [obb_pkg::ACCW-1:0]            acc
);

    logic signed [obb_pkg::OPAW-1:0] a_reg;
    logic signed [obb_pkg::OPBW-1:0] b_reg;
    logic signed [obb_pkg::ACCW-1:0] prod_reg;
    logic signed [obb_pkg::ACCW-1:0] acc_reg;
    logic signed [obb_pkg::BLOW:0]   b_lo;
    logic signed [obb_pkg::OPBW-obb_pkg::BLOW-1:0] b_hi;
    logic signed [obb_pkg::BLOW:0]   b_sel;
    logic signed [obb_pkg::OPAW+obb_pkg::BLOW:0]   prod;
    logic signed [obb_pkg::ACCW-1:0] prod_sh;

    // One multiplier: the low slice (unsigned) first, then the high slice carrying the sign.
    always_comb
    begin
        b_lo    = {1'b0, b_reg[obb_pkg::BLOW-1:0]};
        b_hi    = b_reg[obb_pkg::OPBW-1:obb_pkg::BLOW];
        b_sel   = ctl.mul_hi ? (obb_pkg::BLOW+1)'(b_hi) : b_lo;
        prod    = a_reg * b_sel;
        prod_sh = obb_pkg::ACCW'(prod) <<< obb_pkg::BLOW;
    end

    // Operand latch and product register.
    always_ff @(posedge clk)
    begin
        if (ctl.oper)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        if (ctl.mul_lo)
        begin
            prod_reg <= obb_pkg::ACCW'(prod);
        end
        else if (ctl.mul_hi)
        begin
            prod_reg <= prod_sh;
        end
    end

    // Accumulator: loaded with the job's bias, then each partial product is added.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctl.load)
        begin
            acc_reg <= bias;
        end
        else if (ctl.mul_hi || ctl.add)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/obb_ctrl.sv =====
// Sequencer of the collision core: walks matrix, cross-axis, corner and projection jobs.
// Depends on obb_pkg for the state and step enums and the sequencer struct.
`default_nettype none

module obb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          go,
    output obb_pkg::seq_t      seq,
    output logic               busy
);

    obb_pkg::state_t st_reg, st_next;
    obb_pkg::step_t  ph_reg, ph_next;
    logic [1:0] term_reg, term_next;
    logic [3:0] hi_reg, hi_next;
    logic [1:0] lo_reg, lo_next;
    logic [3:0] axis_reg, axis_next;
    logic [1:0] last_term;
    logic       last_job;
    logic       job_st;
    logic       job_end;

    // Job bookkeeping.
    always_comb
    begin
        job_st    = (st_reg == obb_pkg::S_MAT) || (st_reg == obb_pkg::S_CROSS) ||
                    (st_reg == obb_pkg::S_CORN) || (st_reg == obb_pkg::S_PROJ);
        last_term = ((st_reg == obb_pkg::S_CORN) || (st_reg == obb_pkg::S_PROJ)) ? 2'd2 : 2'd1;
        last_job  = 1'b0;
        unique case (st_reg)
            obb_pkg::S_MAT:   last_job = (hi_reg == 4'd5) && (lo_reg == 2'd2);
            obb_pkg::S_CROSS: last_job = (hi_reg == 4'd8) && (lo_reg == 2'd2);
            obb_pkg::S_CORN:  last_job = (hi_reg == 4'd15) && (lo_reg == 2'd2);
            obb_pkg::S_PROJ:  last_job = (hi_reg == 4'd15);
            default:          last_job = 1'b0;
        endcase
        job_end = job_st && (ph_reg == obb_pkg::P_WR) && last_job;
    end

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            obb_pkg::S_IDLE:  if (go) st_next = obb_pkg::S_MAT;
            obb_pkg::S_MAT:   if (job_end) st_next = obb_pkg::S_CROSS;
            obb_pkg::S_CROSS: if (job_end) st_next = obb_pkg::S_CORN;
            obb_pkg::S_CORN:  if (job_end) st_next = obb_pkg::S_PROJ;
            obb_pkg::S_PROJ:  if (job_end) st_next = obb_pkg::S_EVAL1;
            obb_pkg::S_EVAL1: st_next = obb_pkg::S_EVAL2;
            obb_pkg::S_EVAL2: st_next = (axis_reg == obb_pkg::LAST_AXIS) ?
                                        obb_pkg::S_DONE : obb_pkg::S_PROJ;
            obb_pkg::S_DONE:  st_next = obb_pkg::S_IDLE;
            default:          st_next = obb_pkg::S_IDLE;
        endcase
    end

    // Step, term and job counters.
    always_comb
    begin
        ph_next   = ph_reg;
        term_next = term_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        axis_next = axis_reg;
        if ((st_reg == obb_pkg::S_IDLE) && go)
        begin
            ph_next   = obb_pkg::P_ADDR;
            term_next = 2'd0;
            hi_next   = 4'd0;
            lo_next   = 2'd0;
            axis_next = 4'd0;
        end
        else if (st_reg == obb_pkg::S_EVAL2)
        begin
            axis_next = axis_reg + 4'd1;
        end
        else if (job_st)
        begin
            unique case (ph_reg)
                obb_pkg::P_ADDR: ph_next = obb_pkg::P_OPER;
                obb_pkg::P_OPER: ph_next = obb_pkg::P_LO;
                obb_pkg::P_LO:   ph_next = obb_pkg::P_HI;
                obb_pkg::P_HI:   ph_next = obb_pkg::P_ACC;
                obb_pkg::P_ACC:
                begin
                    if (term_reg == last_term)
                    begin
                        ph_next = obb_pkg::P_WR;
                    end
                    else
                    begin
                        ph_next   = obb_pkg::P_ADDR;
                        term_next = term_reg + 2'd1;
                    end
                end
                obb_pkg::P_WR:
                begin
                    ph_next   = obb_pkg::P_ADDR;
                    term_next = 2'd0;
                    if (last_job)
                    begin
                        hi_next = 4'd0;
                        lo_next = 2'd0;
                    end
                    else if ((st_reg == obb_pkg::S_PROJ) || (lo_reg == 2'd2))
                    begin
                        hi_next = hi_reg + 4'd1;
                        lo_next = 2'd0;
                    end
                    else
                    begin
                        lo_next = lo_reg + 2'd1;
                    end
                end
                default: ph_next = obb_pkg::P_ADDR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= obb_pkg::S_IDLE;
            ph_reg   <= obb_pkg::P_ADDR;
            term_reg <= 2'd0;
            hi_reg   <= 4'd0;
            lo_reg   <= 2'd0;
            axis_reg <= 4'd0;
        end
        else
        begin
            st_reg   <= st_next;
            ph_reg   <= ph_next;
            term_reg <= term_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            axis_reg <= axis_next;
        end
    end

    // Outputs.
    always_comb
    begin
        busy     = (st_reg != obb_pkg::S_IDLE);
        seq.st   = st_reg;
        seq.ph   = ph_reg;
        seq.term = term_reg;
        seq.hi   = hi_reg;
        seq.lo   = lo_reg;
        seq.axis = axis_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/obb_separating_axis_collision_core.sv =====
// Top level of the oriented-box collision core: box storage, axis and corner stores, results.
// Depends on obb_pkg, obb_ctrl and obb_mac.
//
// A beat with box_select low loads the first box and gives no result. A beat with box_select
// high supplies the second box and runs the separating axis test; busy stays high until the
// result. Every product goes through one shared multiplier that takes a 40-bit operand in
// two 32x21 halves: each product term passes an address, operand, low-half, high-half and
// accumulate step, and each value ends with a write step. The jobs are 18 matrix entries, 27
// cross-axis components, 48 corner coordinates and 240 projections, with compare states
// EVAL1 and EVAL2 after each axis. The result strobe is high in S_DONE, busy falls as S_DONE
// ends, and a new beat is accepted once busy is low. The receiver cannot stall the result, so
// it must take collide, least_axis and overlap_depth in that cycle.
`default_nettype none

module obb_separating_axis_collision_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          box_select,
    input  wire logic signed [31:0]            pos_x,
    input  wire logic signed [31:0]            pos_y,
    input  wire logic signed [31:0]            pos_z,
    input  wire logic signed [15:0]            rot_w,
    input  wire logic signed [15:0]            rot_x,
    input  wire logic signed [15:0]            rot_y,
    input  wire logic signed [15:0]            rot_z,
    input  wire logic [30:0]                   half_x,
    input  wire logic [30:0]                   half_y,
    input  wire logic [30:0]                   half_z,
    output logic                               result_valid,
    output logic                               collide,
    output logic [3:0]                         least_axis,
    output logic signed [31:0]                 overlap_depth
);

    localparam logic signed [obb_pkg::DW-1:0] SAT_MAX = obb_pkg::DW'(64'sd2147483647);
    localparam logic signed [obb_pkg::DW-1:0] SAT_MIN = -obb_pkg::DW'(64'sd2147483648);

    obb_pkg::seq_t     seq;
    obb_pkg::mac_ctl_t mctl;
    obb_pkg::mterm_t   mt;

    logic go;
    logic store;
    logic job_st;

    // First box, reset to zero.
    logic signed [obb_pkg::PW-1:0] p1_reg [3];
    logic [obb_pkg::HW-1:0]        h1_reg [3];
    logic signed [obb_pkg::QW-1:0] q1w_reg, q1x_reg, q1y_reg, q1z_reg;

    // Second box.
    logic signed [obb_pkg::PW-1:0] p2_reg [3];
    logic [obb_pkg::HW-1:0]        h2_reg [3];
    logic signed [obb_pkg::QW-1:0] q2w_reg, q2x_reg, q2y_reg, q2z_reg;

    // Axis and corner stores.
    logic signed [obb_pkg::AW-1:0] axes_mem [obb_pkg::AMEM];
    logic signed [obb_pkg::CW-1:0] corner_mem [obb_pkg::CMEM];
    logic signed [obb_pkg::AW-1:0] rd0_reg, rd1_reg;
    logic signed [obb_pkg::CW-1:0] crd_reg;

    logic [obb_pkg::ADRW-1:0] addr0, addr1, caddr, waddr;
    logic signed [obb_pkg::OPAW-1:0] op_a;
    logic signed [obb_pkg::OPBW-1:0] op_b;
    logic signed [obb_pkg::ACCW-1:0] bias;
    logic signed [obb_pkg::ACCW-1:0] acc;
    logic signed [obb_pkg::ACCW-1:0] res_full;

    // Decode temporaries.
    logic                          mbox;
    logic [3:0]                    mcol;
    logic [3:0]                    me;
    logic signed [obb_pkg::QW-1:0] qa, qb;
    logic signed [obb_pkg::QW+1:0] qa2;
    logic [3:0]                    ij;
    logic [1:0]                    ca, cb;
    logic                          cbox;
    logic [2:0]                    ck;
    logic [obb_pkg::HW-1:0]        hv;
    logic signed [obb_pkg::PW-1:0] pv;
    logic [1:0]                    hsel;

    // Interval tracking and the running best axis.
    logic signed [obb_pkg::TW-1:0] tval;
    logic signed [obb_pkg::TW-1:0] lo1_reg, hi1_reg, lo2_reg, hi2_reg;
    logic signed [obb_pkg::DW-1:0] d1_reg, d2_reg;
    logic signed [obb_pkg::DW-1:0] amt;
    logic signed [obb_pkg::DW-1:0] best_reg;
    logic [3:0]                    best_axis_reg;
    logic                          all_reg;

    assign go    = start && !busy && box_select;
    assign store = start && !busy && !box_select;

    obb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .seq   (seq),
        .busy  (busy)
    );

    obb_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .op_a  (op_a),
        .op_b  (op_b),
        .bias  (bias),
        .acc   (acc)
    );

    // Multiply-accumulate control from the sequencer step.
    always_comb
    begin
        job_st = (seq.st == obb_pkg::S_MAT) || (seq.st == obb_pkg::S_CROSS) ||
                 (seq.st == obb_pkg::S_CORN) || (seq.st == obb_pkg::S_PROJ);
        mctl.load   = job_st && (seq.ph == obb_pkg::P_ADDR) && (seq.term == 2'd0);
        mctl.oper   = job_st && (seq.ph == obb_pkg::P_OPER);
        mctl.mul_lo = job_st && (seq.ph == obb_pkg::P_LO);
        mctl.mul_hi = job_st && (seq.ph == obb_pkg::P_HI);
        mctl.add    = job_st && (seq.ph == obb_pkg::P_ACC);
    end

    // Operand, address and bias selection for the current job and term.
    always_comb
    begin
        mbox = (seq.hi >= 4'd3);
        mcol = mbox ? (seq.hi - 4'd3) : seq.hi;
        me   = 4'(mcol * 4'd3 + {2'b00, seq.lo});
        mt   = obb_pkg::mat_term(me, seq.term[0]);
        qa   = mbox ? obb_pkg::pick4(mt.sa, q2w_reg, q2x_reg, q2y_reg, q2z_reg)
                    : obb_pkg::pick4(mt.sa, q1w_reg, q1x_reg, q1y_reg, q1z_reg);
        qb   = mbox ? obb_pkg::pick4(mt.sb, q2w_reg, q2x_reg, q2y_reg, q2z_reg)
                    : obb_pkg::pick4(mt.sb, q1w_reg, q1x_reg, q1y_reg, q1z_reg);
        qa2  = {qa[obb_pkg::QW-1], qa, 1'b0};
        ij   = obb_pkg::split3(seq.hi);
        ca   = seq.term[0] ? obb_pkg::next3(obb_pkg::next3(seq.lo)) : obb_pkg::next3(seq.lo);
        cb   = seq.term[0] ? obb_pkg::next3(seq.lo) : obb_pkg::next3(obb_pkg::next3(seq.lo));
        cbox = seq.hi[3];
        ck   = seq.hi[2:0];
        hsel = (seq.term == 2'd3) ? 2'd2 : seq.term;
        hv   = cbox ? h2_reg[hsel] : h1_reg[hsel];
        pv   = cbox ? p2_reg[(seq.lo == 2'd3) ? 2'd2 : seq.lo]
                    : p1_reg[(seq.lo == 2'd3) ? 2'd2 : seq.lo];

        addr0 = '0;
        addr1 = '0;
        caddr = '0;
        waddr = '0;
        op_a  = '0;
        op_b  = '0;
        bias  = obb_pkg::RND_HALF;
        unique case (seq.st)
            obb_pkg::S_MAT:
            begin
                op_a  = mt.neg ? -obb_pkg::OPAW'(qa2) : obb_pkg::OPAW'(qa2);
                op_b  = obb_pkg::OPBW'(qb);
                bias  = (mcol[1:0] == seq.lo) ? (obb_pkg::RND_HALF + obb_pkg::ONE_Q28)
                                              : obb_pkg::RND_HALF;
                waddr = 6'({2'b00, seq.hi} * 6'd3 + {4'b0000, seq.lo});
            end
            obb_pkg::S_CROSS:
            begin
                addr0 = 6'({4'b0000, ij[3:2]} * 6'd3 + {4'b0000, ca});
                addr1 = 6'(6'd9 + {4'b0000, ij[1:0]} * 6'd3 + {4'b0000, cb});
                op_a  = seq.term[0] ? -obb_pkg::OPAW'(rd0_reg) : obb_pkg::OPAW'(rd0_reg);
                op_b  = obb_pkg::OPBW'(rd1_reg);
                waddr = 6'(6'd18 + {2'b00, seq.hi} * 6'd3 + {4'b0000, seq.lo});
            end
            obb_pkg::S_CORN:
            begin
                addr0 = 6'({5'b00000, cbox} * 6'd9 + {4'b0000, seq.term} * 6'd3 +
                           {4'b0000, seq.lo});
                op_a  = ck[hsel] ? -obb_pkg::OPAW'({1'b0, hv}) : obb_pkg::OPAW'({1'b0, hv});
                op_b  = obb_pkg::OPBW'(rd0_reg);
                bias  = (obb_pkg::ACCW'(pv) <<< obb_pkg::FRAC) + obb_pkg::RND_HALF;
                waddr = 6'({2'b00, seq.hi} * 6'd3 + {4'b0000, seq.lo});
            end
            obb_pkg::S_PROJ:
            begin
                addr0 = 6'({2'b00, seq.axis} * 6'd3 + {4'b0000, seq.term});
                caddr = 6'({2'b00, seq.hi} * 6'd3 + {4'b0000, seq.term});
                op_a  = obb_pkg::OPAW'(rd0_reg);
                op_b  = crd_reg;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    assign res_full = acc >>> obb_pkg::FRAC;
    assign tval     = res_full[obb_pkg::TW-1:0];

    // Axis store: two read ports, written with matrix entries and cross products.
    always_ff @(posedge clk)
    begin
        if (seq.ph == obb_pkg::P_WR &&
            (seq.st == obb_pkg::S_MAT || seq.st == obb_pkg::S_CROSS))
        begin
            axes_mem[waddr] <= res_full[obb_pkg::AW-1:0];
        end
        if (seq.ph == obb_pkg::P_ADDR && (seq.st == obb_pkg::S_CROSS ||
            seq.st == obb_pkg::S_CORN || seq.st == obb_pkg::S_PROJ))
        begin
            rd0_reg <= axes_mem[addr0];
            rd1_reg <= axes_mem[addr1];
        end
    end

    // Corner store: one read port.
    always_ff @(posedge clk)
    begin
        if (seq.ph == obb_pkg::P_WR && seq.st == obb_pkg::S_CORN)
        begin
            corner_mem[waddr] <= res_full[obb_pkg::CW-1:0];
        end
        if (seq.ph == obb_pkg::P_ADDR && seq.st == obb_pkg::S_PROJ)
        begin
            crd_reg <= corner_mem[caddr];
        end
    end

    // First box storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg[0] <= '0;
            p1_reg[1] <= '0;
            p1_reg[2] <= '0;
            h1_reg[0] <= '0;
            h1_reg[1] <= '0;
            h1_reg[2] <= '0;
            q1w_reg   <= '0;
            q1x_reg   <= '0;
            q1y_reg   <= '0;
            q1z_reg   <= '0;
        end
        else if (store)
        begin
            p1_reg[0] <= pos_x;
            p1_reg[1] <= pos_y;
            p1_reg[2] <= pos_z;
            h1_reg[0] <= half_x;
            h1_reg[1] <= half_y;
            h1_reg[2] <= half_z;
            q1w_reg   <= rot_w;
            q1x_reg   <= rot_x;
            q1y_reg   <= rot_y;
            q1z_reg   <= rot_z;
        end
    end

    // Second box capture.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            p2_reg[0] <= pos_x;
            p2_reg[1] <= pos_y;
            p2_reg[2] <= pos_z;
            h2_reg[0] <= half_x;
            h2_reg[1] <= half_y;
            h2_reg[2] <= half_z;
            q2w_reg   <= rot_w;
            q2x_reg   <= rot_x;
            q2y_reg   <= rot_y;
            q2z_reg   <= rot_z;
        end
    end

    // Projection intervals for the current axis.
    always_ff @(posedge clk)
    begin
        if (seq.st == obb_pkg::S_PROJ && seq.ph == obb_pkg::P_WR)
        begin
            if (!cbox)
            begin
                if (ck == 3'd0 || tval < lo1_reg) lo1_reg <= tval;
                if (ck == 3'd0 || tval > hi1_reg) hi1_reg <= tval;
            end
            else
            begin
                if (ck == 3'd0 || tval < lo2_reg) lo2_reg <= tval;
                if (ck == 3'd0 || tval > hi2_reg) hi2_reg <= tval;
            end
        end
        if (seq.st == obb_pkg::S_EVAL1)
        begin
            d1_reg <= obb_pkg::DW'(hi1_reg) - obb_pkg::DW'(lo2_reg);
            d2_reg <= obb_pkg::DW'(hi2_reg) - obb_pkg::DW'(lo1_reg);
        end
    end

    assign amt = (d2_reg < d1_reg) ? d2_reg : d1_reg;

    // Overlap flag and least-overlap axis.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_reg       <= 1'b0;
            best_axis_reg <= 4'd0;
            best_reg      <= '0;
        end
        else if (go)
        begin
            all_reg <= 1'b1;
        end
        else if (seq.st == obb_pkg::S_EVAL2)
        begin
            if (d1_reg < 0 || d2_reg < 0)
            begin
                all_reg <= 1'b0;
            end
            if (seq.axis == 4'd0 || amt < best_reg)
            begin
                best_reg      <= amt;
                best_axis_reg <= seq.axis;
            end
        end
    end

    // Result beat.
    always_comb
    begin
        result_valid = (seq.st == obb_pkg::S_DONE);
        collide      = all_reg;
        least_axis   = best_axis_reg;
        if (best_reg > SAT_MAX)
        begin
            overlap_depth = 32'sh7FFFFFFF;
        end
        else if (best_reg < SAT_MIN)
        begin
            overlap_depth = 32'sh80000000;
        end
        else
        begin
            overlap_depth = best_reg[31:0];
        end
    end

endmodule

`default_nettype wire
